// File: hdl/indexed_list_store_assert.svh
// Assertion macros shared by the indexed list store.
// Depends on nothing; included by the top level only.
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ILS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed_list_store: assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed_list_store: assertion failed");

`endif

// File: hdl/ils_pkg.sv
// Shared types and constants for the indexed list store.
// Used by the controller, the datapath and the top level; depends on nothing.
package ils_pkg;

    // Field widths and store size.
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 2;
    localparam int CNT_W    = 7;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Value returned by anything but a successful read.
    localparam logic signed [VAL_W-1:0] NONE_VALUE = '1;

    // What the decoded operation does to the store.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_READ,
        ACT_INSERT,
        ACT_DELETE
    } t_act;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_COMMIT,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic place;
        logic remove;
        logic respond;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_act act;
        logic walk_done;
    } t_dp_stat;

endpackage

// File: hdl/ils_ctrl.sv
// Controller state machine for the indexed list store.
// Depends on ils_pkg; drives the datapath through t_ctl_cmd.
module ils_ctrl import ils_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.act == ACT_INSERT || i_stat.act == ACT_DELETE) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SHIFT: begin
                if (i_stat.walk_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: n_state = S_RESP;
            S_RESP:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_DECODE: o_cmd.setup = 1'b1;
            S_SHIFT:  o_cmd.step  = !i_stat.walk_done;
            S_COMMIT: begin
                o_cmd.place  = (i_stat.act == ACT_INSERT);
                o_cmd.remove = (i_stat.act == ACT_DELETE);
            end
            S_RESP:   o_cmd.respond = 1'b1;
            default:  o_busy = 1'b1;
        endcase
    end

endmodule

// File: hdl/ils_dp.sv
// Datapath of the indexed list store: element memory, count, decode and walk.
// Depends on ils_pkg; takes commands from ils_ctrl.
module ils_dp import ils_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl_cmd                i_cmd,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic signed [POS_W-1:0] i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output t_dp_stat                o_stat,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic [ST_W-1:0]         o_status,
    output logic [CNT_W-1:0]        o_count
);

    // Element memory.
    logic [VAL_W-1:0] mem [CAPACITY];

    logic [OP_W-1:0]         r_op;
    logic signed [POS_W-1:0] r_pos;
    logic [VAL_W-1:0]        r_value;
    logic [CNT_W-1:0]        r_count;
    logic [ST_W-1:0]         r_status;
    logic                    r_rd_ok;
    logic [CNT_W-1:0]        r_slot;
    logic [CNT_W-1:0]        r_src;
    logic [CNT_W-1:0]        r_left;
    logic                    r_up;
    logic [ADDR_W-1:0]       r_wa;
    logic                    r_pend;
    logic [VAL_W-1:0]        r_rdata;

    logic              pos_neg;
    logic [POS_W-1:0]  pos_mag;
    logic [POS_W-1:0]  cnt_ext;
    logic              pos_lt;
    logic              pos_gt;
    logic              pos_le0;
    logic              full;
    t_act              dec_act;
    logic [ST_W-1:0]   dec_st;
    logic [CNT_W-1:0]  dec_slot;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [VAL_W-1:0]  mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    // Position compares against the current count.
    assign pos_neg = r_pos[POS_W-1];
    assign pos_mag = {1'b0, r_pos[POS_W-2:0]};
    assign cnt_ext = {{(POS_W-CNT_W){1'b0}}, r_count};
    assign pos_lt  = !pos_neg && (pos_mag < cnt_ext);
    assign pos_gt  = !pos_neg && (pos_mag > cnt_ext);
    assign pos_le0 = pos_neg || (r_pos == '0);
    assign full    = (r_count == CNT_W'(CAPACITY));

    // Operation decode: action, status and target slot.
    always_comb begin
        dec_act  = ACT_NONE;
        dec_st   = ST_RANGE;
        dec_slot = '0;
        case (r_op)
            OP_READ: begin
                if (pos_lt) begin
                    dec_act  = ACT_READ;
                    dec_st   = ST_OK;
                    dec_slot = r_pos[CNT_W-1:0];
                end
            end
            OP_INS_HEAD: begin
                if (full) begin
                    dec_st = ST_FULL;
                end else begin
                    dec_act = ACT_INSERT;
                    dec_st  = ST_OK;
                end
            end
            OP_INS_TAIL: begin
                if (full) begin
                    dec_st = ST_FULL;
                end else begin
                    dec_act  = ACT_INSERT;
                    dec_st   = ST_OK;
                    dec_slot = r_count;
                end
            end
            OP_INS_AT: begin
                if (pos_le0) begin
                    if (full) begin
                        dec_st = ST_FULL;
                    end else begin
                        dec_act = ACT_INSERT;
                        dec_st  = ST_OK;
                    end
                end else if (pos_gt) begin
                    dec_st = ST_RANGE;
                end else if (full) begin
                    dec_st = ST_FULL;
                end else begin
                    dec_act  = ACT_INSERT;
                    dec_st   = ST_OK;
                    dec_slot = r_pos[CNT_W-1:0];
                end
            end
            OP_DELETE: begin
                if (pos_lt) begin
                    dec_act  = ACT_DELETE;
                    dec_st   = ST_OK;
                    dec_slot = r_pos[CNT_W-1:0];
                end
            end
            default: dec_act = ACT_NONE;
        endcase
    end

    // Memory port selection: the new value has priority over a pending move.
    assign mem_we = i_cmd.place || r_pend;
    assign mem_wa = i_cmd.place ? r_slot[ADDR_W-1:0] : r_wa;
    assign mem_wd = i_cmd.place ? r_value : r_rdata;
    assign mem_re = (i_cmd.setup && dec_act == ACT_READ) || i_cmd.step;
    assign mem_ra = i_cmd.step ? r_src[ADDR_W-1:0] : dec_slot[ADDR_W-1:0];

    // Element memory with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    // Captured operation word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_pos   <= i_position;
            r_value <= i_value;
        end
    end

    // Walk setup and stepping; an insert walks down, a delete walks up.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_status <= dec_st;
            r_slot   <= dec_slot;
            if (dec_act == ACT_INSERT) begin
                r_up   <= 1'b0;
                r_src  <= r_count - CNT_W'(1);
                r_left <= r_count - dec_slot;
            end else begin
                r_up   <= 1'b1;
                r_src  <= dec_slot + CNT_W'(1);
                r_left <= r_count - dec_slot - CNT_W'(1);
            end
        end else if (i_cmd.step) begin
            r_left <= r_left - CNT_W'(1);
            if (r_up) begin
                r_src <= r_src + CNT_W'(1);
                r_wa  <= r_src[ADDR_W-1:0] - ADDR_W'(1);
            end else begin
                r_src <= r_src - CNT_W'(1);
                r_wa  <= r_src[ADDR_W-1:0] + ADDR_W'(1);
            end
        end
    end

    // Control state: count, pending move and read flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_pend <= i_cmd.step;
            if (i_cmd.setup) begin
                r_rd_ok <= (dec_act == ACT_READ);
            end
            if (i_cmd.place) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.remove) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_stat.act       = dec_act;
    assign o_stat.walk_done = (r_left == '0);
    assign o_read_value     = r_rd_ok ? signed'(r_rdata) : NONE_VALUE;
    assign o_status         = r_status;
    assign o_count          = r_count;

endmodule

// File: hdl/indexed_list_store.sv
// Top level of the indexed list store: controller plus datapath.
// Depends on ils_pkg, ils_ctrl, ils_dp and indexed_list_store_assert.svh.
//
// Usage: drive i_opcode, i_position and i_value with start high; the word is
// taken at a rising edge where start is high and busy is low. busy stays high
// until the result has been shown. Each result word appears on o_read_value,
// o_status and o_count for exactly one cycle, marked by o_done; the receiver
// cannot stall it and must take it in that cycle.
// Sequence: a read or any rejected operation passes through decode and then
// gives o_done. An insert or delete moves m stored elements one per cycle
// through the memory's read and write ports, then commits the new value or the
// removal, and then gives o_done. At most CAPACITY - 1 elements move. A new
// word can be taken in the cycle after o_done.
// Reset (synchronous, active low) empties the store and returns to idle; the
// memory contents are not cleared, since no entry at or past the count is
// ever read.
`include "indexed_list_store_assert.svh"
module indexed_list_store import ils_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic signed [POS_W-1:0] i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_done,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic [ST_W-1:0]         o_status,
    output logic [CNT_W-1:0]        o_count
);

    t_ctl_cmd cmd;
    t_dp_stat stat;

    // Sequencer.
    ils_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Storage and decode.
    ils_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_stat       (stat),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    assign o_done = cmd.respond;

    // The count never exceeds the store size.
    `ILS_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, o_count <= CNT_W'(CAPACITY))
    // A full report only comes from a full store.
    `ILS_ASSERT_NOW(a_full_cnt, i_clk, i_rst_n, o_done && o_status == ST_FULL, o_count == CNT_W'(CAPACITY))
    // An accepted word makes the block busy in the next cycle.
    `ILS_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, start && !busy, busy)
    // Each result word is shown for one cycle only.
    `ILS_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)

endmodule

// File: sim/indexed_list_store_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_store: a directed table, then random words.
// Depends on ils_pkg and the indexed_list_store RTL; every result is checked in order.
module indexed_list_store_tb;
    import ils_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int RAND_WORDS     = 550;
    localparam int CALM_WORDS     = 60;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 8 * (CAPACITY + 5 + 8);
    localparam int DIR_ROWS       = 26;

    // Opcodes the block does not define; they must be rejected.
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [ST_W-1:0]         status;
        logic [CNT_W-1:0]        count;
    } t_result;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [POS_W-1:0] pos;
        logic signed [VAL_W-1:0] val;
        logic                    fixed_exp;
        t_result                 exp;
    } t_dir_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [OP_W-1:0]         i_opcode;
    logic signed [POS_W-1:0] i_position;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_done;
    logic signed [VAL_W-1:0] o_read_value;
    logic [ST_W-1:0]         o_status;
    logic [CNT_W-1:0]        o_count;

    // Predicted contents of the list and the results still to come.
    logic signed [VAL_W-1:0] list_mem [CAPACITY];
    int                      list_len = 0;
    t_result                 pending_results [$];
    int                      n_fail = 0;
    int                      idle_cycles = 0;

    // Directed words: empty store, value extremes, every opcode and every range rejection.
    // Rows with fixed_exp set carry their result; the others use the predictor.
    t_dir_row dir_table [DIR_ROWS] = '{
        '{OP_READ,     8'sd0,   32'sd0,          1'b1, '{NONE_VALUE, ST_RANGE, 7'd0}},
        '{OP_DELETE,   8'sd0,   32'sd0,          1'b1, '{NONE_VALUE, ST_RANGE, 7'd0}},
        '{OP_INS_AT,   8'sd1,   32'sd5,          1'b1, '{NONE_VALUE, ST_RANGE, 7'd0}},
        '{OP_INS_AT,   8'sh80,  32'sh7FFFFFFF,   1'b1, '{NONE_VALUE, ST_OK,    7'd1}},
        '{OP_INS_TAIL, 8'sd0,   32'sh80000000,   1'b1, '{NONE_VALUE, ST_OK,    7'd2}},
        '{OP_READ,     8'sd1,   32'sd0,          1'b0, '0},
        '{OP_INS_HEAD, 8'sh7F,  32'sd0,          1'b1, '{NONE_VALUE, ST_OK,    7'd3}},
        '{OP_INS_AT,   8'sd3,   32'shFFFFFFFF,   1'b1, '{NONE_VALUE, ST_OK,    7'd4}},
        '{OP_INS_AT,   8'sd2,   32'sh5A5A5A5A,   1'b0, '0},
        '{OP_READ,     8'sd4,   32'sd0,          1'b0, '0},
        '{OP_READ,     8'sd0,   32'sd0,          1'b0, '0},
        '{OP_READ,     8'sd5,   32'sd0,          1'b1, '{NONE_VALUE, ST_RANGE, 7'd5}},
        '{OP_READ,     8'sh7F,  32'sd0,          1'b1, '{NONE_VALUE, ST_RANGE, 7'd5}},
        '{OP_READ,     -8'sd1,  32'sd0,          1'b1, '{NONE_VALUE, ST_RANGE, 7'd5}},
        '{OP_READ,     8'sh80,  32'sd0,          1'b1, '{NONE_VALUE, ST_RANGE, 7'd5}},
        '{OP_INS_AT,   8'sh7F,  32'sd1,          1'b1, '{NONE_VALUE, ST_RANGE, 7'd5}},
        '{OP_INS_AT,   8'sd6,   32'sd1,          1'b1, '{NONE_VALUE, ST_RANGE, 7'd5}},
        '{OP_SPARE_5,  8'sd0,   32'sd1,          1'b1, '{NONE_VALUE, ST_RANGE, 7'd5}},
        '{OP_SPARE_6,  8'sd1,   32'shFFFFFFFF,   1'b1, '{NONE_VALUE, ST_RANGE, 7'd5}},
        '{OP_SPARE_7,  -8'sd1,  32'sh80000000,   1'b1, '{NONE_VALUE, ST_RANGE, 7'd5}},
        '{OP_DELETE,   -8'sd1,  32'sd0,          1'b1, '{NONE_VALUE, ST_RANGE, 7'd5}},
        '{OP_DELETE,   8'sd5,   32'sd0,          1'b1, '{NONE_VALUE, ST_RANGE, 7'd5}},
        '{OP_DELETE,   8'sd0,   32'sd0,          1'b0, '0},
        '{OP_DELETE,   8'sd3,   32'sd0,          1'b0, '0},
        '{OP_DELETE,   8'sd1,   32'sd0,          1'b0, '0},
        '{OP_READ,     8'sd1,   32'sd0,          1'b0, '0}
    };

    indexed_list_store u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_done       (o_done),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Apply one word to the predicted list and return the result it should give.
    function automatic t_result apply_list_op(input logic [OP_W-1:0] op,
                                              input logic signed [POS_W-1:0] pos,
                                              input logic signed [VAL_W-1:0] val);
        t_result r;
        int      slot;
        bit      do_insert;
        r         = '{NONE_VALUE, ST_OK, '0};
        slot      = 0;
        do_insert = 1'b0;
        case (op)
            OP_READ: begin
                if (pos >= 0 && int'(pos) < list_len) begin
                    r.read_value = list_mem[int'(pos)];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            OP_INS_HEAD: begin
                do_insert = 1'b1;
            end
            OP_INS_TAIL: begin
                do_insert = 1'b1;
                slot      = list_len;
            end
            OP_INS_AT: begin
                // Positions at or below zero go to the head; past the count is rejected.
                if (pos <= 0) begin
                    do_insert = 1'b1;
                end else if (int'(pos) > list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    do_insert = 1'b1;
                    slot      = int'(pos);
                end
            end
            OP_DELETE: begin
                if (pos < 0 || int'(pos) >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int k = int'(pos); k < list_len - 1; k++) begin
                        list_mem[k] = list_mem[k + 1];
                    end
                    list_len--;
                end
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        // A full store refuses every insert that got past the position check.
        if (do_insert) begin
            if (list_len >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                for (int k = list_len; k > slot; k--) begin
                    list_mem[k] = list_mem[k - 1];
                end
                list_mem[slot] = val;
                list_len++;
            end
        end
        r.count = CNT_W'(list_len);
        return r;
    endfunction

    // Present one word and hold it until the block takes it.
    task automatic send_word(input logic [OP_W-1:0] op, input logic signed [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val, input bit fixed_exp,
                             input t_result fixed_res);
        t_result res;
        @(negedge i_clk);
        start      <= 1'b1;
        i_opcode   <= op;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (busy);
        res = apply_list_op(op, pos, val);
        pending_results.push_back(fixed_exp ? fixed_res : res);
    endtask

    // Leave start low for the given number of cycles.
    task automatic idle_sender(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_done) begin
            got = '{o_read_value, o_status, o_count};
            if (pending_results.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS) begin
                    $display("unexpected result: value %0d status %0d count %0d",
                             got.read_value, got.status, got.count);
                end
            end else begin
                want = pending_results.pop_front();
                if (got.read_value !== want.read_value || got.status !== want.status ||
                    got.count !== want.count) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS) begin
                        $display("mismatch: expected value %0d status %0d count %0d, got value %0d status %0d count %0d",
                                 want.read_value, want.status, want.count,
                                 got.read_value, got.status, got.count);
                    end
                end
            end
        end
        if (!i_rst_n || o_done || (start && !busy)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random fill and drain passes.
    initial begin
        logic [OP_W-1:0]         op;
        logic signed [POS_W-1:0] pos;
        logic signed [VAL_W-1:0] val;
        int                      pick;
        bit                      filling;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_opcode   = OP_READ;
        i_position = '0;
        i_value    = '0;
        filling    = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[n]) begin
            if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 8));
            send_word(dir_table[n].op, dir_table[n].pos, dir_table[n].val,
                      dir_table[n].fixed_exp, dir_table[n].exp);
        end

        for (int n = 0; n < RAND_WORDS; n++) begin
            // Linger a little at full and at empty before turning around.
            if (filling && list_len == CAPACITY && $urandom_range(0, 3) == 0) begin
                filling = 1'b0;
            end else if (!filling && list_len == 0 && $urandom_range(0, 3) == 0) begin
                filling = 1'b1;
            end

            pick = $urandom_range(0, 99);
            if (filling) begin
                if (pick < 15)      op = OP_READ;
                else if (pick < 30) op = OP_INS_HEAD;
                else if (pick < 45) op = OP_INS_TAIL;
                else if (pick < 78) op = OP_INS_AT;
                else if (pick < 95) op = OP_DELETE;
                else                op = OP_SPARE_5 + OP_W'($urandom_range(0, 2));
            end else begin
                if (pick < 15)      op = OP_READ;
                else if (pick < 20) op = OP_INS_HEAD;
                else if (pick < 25) op = OP_INS_TAIL;
                else if (pick < 35) op = OP_INS_AT;
                else if (pick < 95) op = OP_DELETE;
                else                op = OP_SPARE_5 + OP_W'($urandom_range(0, 2));
            end

            // Mostly valid positions, some just past the count, some anything at all.
            pick = $urandom_range(0, 99);
            if (pick < 85)      pos = POS_W'($urandom_range(0, list_len));
            else if (pick < 92) pos = POS_W'(list_len + $urandom_range(1, 3));
            else                pos = POS_W'($urandom());
            val = $urandom();

            if (n < RAND_WORDS - CALM_WORDS && $urandom_range(0, 2) == 0) begin
                idle_sender($urandom_range(1, 8));
            end
            send_word(op, pos, val, 1'b0, '0);
        end
        idle_sender(1);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
